FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked assertions with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_HOLDS(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error(msg);

// The condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk_sig, rst_n_sig, cond, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) !(cond)) \
		else $error(msg);

`endif

FILE: sv/drbe_pkg.sv
// ----------------------------------------------------------------------------
// drbe_pkg
// Types and constants shared by the decode rate budget estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package drbe_pkg;

	localparam int MS_W     = 16;
	localparam int MBS_W    = 17;
	localparam int RATE_W   = 16;
	localparam int FRAME_W  = 13;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int Q8_SHIFT = 8;

	// Sample division: (count << 8) / elapsed.
	localparam int DIVIDEND_W = MBS_W + Q8_SHIFT;
	localparam int DIVISOR_W  = MS_W;

	// Budget product: usable * rate.
	localparam int PROD_W   = MS_W + RATE_W;
	localparam int BUDGET_W = PROD_W - Q8_SHIFT;

	// Macroblock grid from the frame size.
	localparam int MB_SIDE_LOG2 = 4;
	localparam int MB_DIM_W     = FRAME_W + 1 - MB_SIDE_LOG2;
	localparam int TOTAL_W      = 2 * MB_DIM_W;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPARE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GUARD        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_RATE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd4;

	localparam logic [MS_W-1:0]    RST_MIN_SPARE    = 16'd4;
	localparam logic [MS_W-1:0]    RST_GUARD        = 16'd2;
	localparam logic [RATE_W-1:0]  RST_DEFAULT_RATE = 16'd256;
	localparam logic [FRAME_W-1:0] RST_FRAME_WIDTH  = 13'd320;
	localparam logic [FRAME_W-1:0] RST_FRAME_HEIGHT = 13'd240;

	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_QUERY  = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_BLEND,
		S_MUL,
		S_CLAMP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic div_start;
		logic mul_start;
		logic out_load;
	} ctrl_t;

endpackage

`default_nettype wire

FILE: sv/drbe_div.sv
// ----------------------------------------------------------------------------
// drbe_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module drbe_div #(
	parameter int DIVIDEND_W = 25,
	parameter int DIVISOR_W  = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [DIVISOR_W-1:0]  divisor,
	output logic                       busy,
	output logic                       done,
	output logic [DIVIDEND_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  divisor_q;

	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;

	// Bring down the next dividend bit and try a subtraction.
	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_W-1]};
		diff  = trial - {1'b0, divisor_q};
		fits  = trial >= {1'b0, divisor_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q     <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

FILE: sv/drbe_mul.sv
// ----------------------------------------------------------------------------
// drbe_mul
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module drbe_mul #(
	parameter int A_W = 16,
	parameter int B_W = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [A_W-1:0]   mcand,
	input  wire logic [B_W-1:0]   mplier,
	output logic                  busy,
	output logic                  done,
	output logic [A_W+B_W-1:0]    product
);

	localparam int CNT_W = $clog2(B_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(B_W - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [A_W-1:0]        mcand_q;
	logic [A_W+B_W-1:0]    prod_q;
	logic [A_W:0]          partial;

	// The low half holds the multiplier bits not yet used; the high half
	// accumulates and shifts right into the low half as bits retire.
	always_comb begin
		partial = {1'b0, prod_q[A_W+B_W-1:B_W]} + (prod_q[0] ? {1'b0, mcand_q} : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mcand;
			prod_q  <= {{A_W{1'b0}}, mplier};
		end else if (busy_q) begin
			prod_q <= {partial, prod_q[B_W-1:1]};
		end
	end

	assign busy    = busy_q;
	assign done    = done_q;
	assign product = prod_q;

endmodule

`default_nettype wire

FILE: sv/decode_rate_budget_estimator.sv
// ----------------------------------------------------------------------------
// decode_rate_budget_estimator
// Running Q8 decode rate average and macroblock budget for spare time.
// ----------------------------------------------------------------------------
// One item is in work at a time and each gives one result. A rate sample
// runs the bit-serial divider for 25 steps, one quotient bit per cycle.
// A budget query runs the bit-serial multiplier for 16 steps. An empty
// sample, or a query with spare time under the minimum, skips the
// arithmetic. The result sits in an output register, so the next item
// can be taken while it waits to be read. Configuration writes take
// effect at once and should only be made idle.
`default_nettype none

`include "assert_macros.svh"

module decode_rate_budget_estimator (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// Configuration write port
	input  wire logic                                 cfg_we,
	input  wire logic [drbe_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [drbe_pkg::CFG_DATA_W-1:0]      cfg_data,
	// Input channel
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 func,
	input  wire logic [drbe_pkg::MS_W-1:0]            elapsed_time,
	input  wire logic [drbe_pkg::MBS_W-1:0]           mb_count,
	input  wire logic [drbe_pkg::MS_W-1:0]            spare_time,
	input  wire logic [drbe_pkg::MBS_W-1:0]           pic_size_mbs,
	// Result channel
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [drbe_pkg::MBS_W-1:0]                budget_mbs,
	output logic [drbe_pkg::RATE_W-1:0]               avg_rate_q8
);

	localparam int MS_W      = drbe_pkg::MS_W;
	localparam int MBS_W     = drbe_pkg::MBS_W;
	localparam int RATE_W    = drbe_pkg::RATE_W;
	localparam int FRAME_W   = drbe_pkg::FRAME_W;
	localparam int DIVIDEND_W = drbe_pkg::DIVIDEND_W;
	localparam int PROD_W    = drbe_pkg::PROD_W;
	localparam int BUDGET_W  = drbe_pkg::BUDGET_W;
	localparam int MB_DIM_W  = drbe_pkg::MB_DIM_W;
	localparam int TOTAL_W   = drbe_pkg::TOTAL_W;
	localparam int BLEND_W   = DIVIDEND_W + 1;

	// Configuration registers
	logic [MS_W-1:0]    min_spare_q;
	logic [MS_W-1:0]    guard_q;
	logic [RATE_W-1:0]  def_rate_q;
	logic [FRAME_W-1:0] frame_w_q;
	logic [FRAME_W-1:0] frame_h_q;

	// Item state
	drbe_pkg::state_t state_q, state_next;
	drbe_pkg::ctrl_t  ctrl;
	logic [RATE_W-1:0]  avg_q;
	logic [MBS_W-1:0]   budget_q;
	logic [MBS_W-1:0]   done_mbs_q;
	logic [MBS_W-1:0]   pic_q;
	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W-1:0] remain_q;
	logic               out_valid_q;
	logic [MBS_W-1:0]   out_budget_q;
	logic [RATE_W-1:0]  out_avg_q;

	logic in_xfer;
	logic sample_ok;
	logic query_low;
	logic out_free;

	logic [MS_W-1:0]       usable;
	logic [RATE_W-1:0]     rate;
	logic                  div_busy, div_done;
	logic [DIVIDEND_W-1:0] quotient;
	logic                  mul_busy, mul_done;
	logic [PROD_W-1:0]     product;

	logic [DIVIDEND_W-1:0] sample;
	logic [BLEND_W-1:0]    blend_sum;
	logic [MB_DIM_W-1:0]   w_mbs, h_mbs;
	logic [TOTAL_W-1:0]    grid_mbs;
	logic [BUDGET_W-1:0]   raw_budget;
	logic [BUDGET_W-1:0]   floor_budget;
	logic [BUDGET_W-1:0]   cap_budget;
	logic [MBS_W-1:0]      final_budget;

	// ------------------------------------------------------------------
	// Configuration
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_spare_q <= drbe_pkg::RST_MIN_SPARE;
			guard_q     <= drbe_pkg::RST_GUARD;
			def_rate_q  <= drbe_pkg::RST_DEFAULT_RATE;
			frame_w_q   <= drbe_pkg::RST_FRAME_WIDTH;
			frame_h_q   <= drbe_pkg::RST_FRAME_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				drbe_pkg::REG_MIN_SPARE:    min_spare_q <= cfg_data;
				drbe_pkg::REG_GUARD:        guard_q     <= cfg_data;
				drbe_pkg::REG_DEFAULT_RATE: def_rate_q  <= cfg_data;
				drbe_pkg::REG_FRAME_WIDTH:  frame_w_q   <= cfg_data[FRAME_W-1:0];
				drbe_pkg::REG_FRAME_HEIGHT: frame_h_q   <= cfg_data[FRAME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Item decode at the input transfer
	// ------------------------------------------------------------------
	assign in_xfer   = in_valid && ctrl.in_ready;
	assign sample_ok = (elapsed_time != '0) && (mb_count != '0);
	assign query_low = spare_time < min_spare_q;
	assign out_free  = !out_valid_q || out_ready;

	assign usable = (spare_time > guard_q) ? (spare_time - guard_q) : MS_W'(1);
	assign rate   = (avg_q != '0) ? avg_q : def_rate_q;

	drbe_div #(
		.DIVIDEND_W (DIVIDEND_W),
		.DIVISOR_W  (drbe_pkg::DIVISOR_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctrl.div_start),
		.dividend ({mb_count, {drbe_pkg::Q8_SHIFT{1'b0}}}),
		.divisor  (elapsed_time),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quotient)
	);

	drbe_mul #(
		.A_W (RATE_W),
		.B_W (MS_W)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ctrl.mul_start),
		.mcand   (rate),
		.mplier  (usable),
		.busy    (mul_busy),
		.done    (mul_done),
		.product (product)
	);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			drbe_pkg::S_IDLE: begin
				if (in_valid) begin
					if (func == drbe_pkg::FUNC_SAMPLE) begin
						state_next = sample_ok ? drbe_pkg::S_DIV : drbe_pkg::S_DONE;
					end else begin
						state_next = query_low ? drbe_pkg::S_DONE : drbe_pkg::S_MUL;
					end
				end
			end
			drbe_pkg::S_DIV: begin
				if (div_done) begin
					state_next = drbe_pkg::S_BLEND;
				end
			end
			drbe_pkg::S_BLEND: state_next = drbe_pkg::S_DONE;
			drbe_pkg::S_MUL: begin
				if (mul_done) begin
					state_next = drbe_pkg::S_CLAMP;
				end
			end
			drbe_pkg::S_CLAMP: state_next = drbe_pkg::S_DONE;
			drbe_pkg::S_DONE: begin
				if (out_free) begin
					state_next = drbe_pkg::S_IDLE;
				end
			end
			default: state_next = drbe_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			drbe_pkg::S_IDLE: begin
				ctrl.in_ready  = 1'b1;
				ctrl.div_start = in_valid && (func == drbe_pkg::FUNC_SAMPLE) && sample_ok;
				ctrl.mul_start = in_valid && (func == drbe_pkg::FUNC_QUERY) && !query_low;
			end
			drbe_pkg::S_DONE: ctrl.out_load = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= drbe_pkg::S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// ------------------------------------------------------------------
	// Average update
	// ------------------------------------------------------------------
	assign sample    = (quotient == '0) ? DIVIDEND_W'(1) : quotient;
	assign blend_sum = BLEND_W'({avg_q, 1'b0}) + BLEND_W'(avg_q) + BLEND_W'(sample)
		+ BLEND_W'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= '0;
		end else if (state_q == drbe_pkg::S_BLEND) begin
			// A first sample loads the average; later ones blend 3:1 with rounding.
			if (avg_q == '0) begin
				avg_q <= sample[RATE_W-1:0];
			end else begin
				avg_q <= blend_sum[RATE_W+1:2];
			end
		end
	end

	// ------------------------------------------------------------------
	// Budget
	// ------------------------------------------------------------------
	assign w_mbs    = MB_DIM_W'(((FRAME_W+1)'(frame_w_q) + (FRAME_W+1)'(15))
		>> drbe_pkg::MB_SIDE_LOG2);
	assign h_mbs    = MB_DIM_W'(((FRAME_W+1)'(frame_h_q) + (FRAME_W+1)'(15))
		>> drbe_pkg::MB_SIDE_LOG2);
	assign grid_mbs = w_mbs * h_mbs;

	// Picture size and the macroblocks left settle while the multiplier runs.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			done_mbs_q <= mb_count;
			pic_q      <= pic_size_mbs;
		end
		if (state_q == drbe_pkg::S_MUL) begin
			total_q  <= (pic_q != '0) ? TOTAL_W'(pic_q) : grid_mbs;
			remain_q <= (total_q > TOTAL_W'(done_mbs_q)) ? (total_q - TOTAL_W'(done_mbs_q))
				: TOTAL_W'(1);
		end
	end

	assign raw_budget   = product[PROD_W-1:drbe_pkg::Q8_SHIFT];
	assign floor_budget = (raw_budget == '0) ? BUDGET_W'(1) : raw_budget;
	assign cap_budget   = (floor_budget > BUDGET_W'(remain_q)) ? BUDGET_W'(remain_q)
		: floor_budget;
	assign final_budget = (cap_budget > BUDGET_W'({MBS_W{1'b1}})) ? {MBS_W{1'b1}}
		: cap_budget[MBS_W-1:0];

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			budget_q <= '0;
		end else if (state_q == drbe_pkg::S_CLAMP) begin
			budget_q <= final_budget;
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			out_budget_q <= budget_q;
			out_avg_q    <= avg_q;
		end
	end

	assign in_ready    = ctrl.in_ready;
	assign out_valid   = out_valid_q;
	assign budget_mbs  = out_budget_q;
	assign avg_rate_q8 = out_avg_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`ASSERT_NEVER(a_units_exclusive, clk, arst_n, div_busy && mul_busy,
		"divider and multiplier busy at once")
	`ASSERT_NEVER(a_idle_units_quiet, clk, arst_n, ctrl.in_ready && (div_busy || mul_busy),
		"arithmetic unit busy while taking a new item")
	`ASSERT_HOLDS(a_query_keeps_avg, clk, arst_n,
		(state_q == drbe_pkg::S_MUL) |=> (avg_q == $past(avg_q)),
		"budget query changed the running average")
	`ASSERT_HOLDS(a_low_spare_zero, clk, arst_n,
		(in_xfer && (func == drbe_pkg::FUNC_QUERY) && query_low) |=> (budget_q == '0),
		"query under minimum spare time gave a nonzero budget")

endmodule

`default_nettype wire
